### hdl/tam_pkg.sv
// Shared types, constants and helper functions of the tilt-angle monitor.
package tam_pkg;

   // Angle accumulator: degrees with 16 fraction bits, room for a half turn plus rotation.
   localparam int ACC_W = 26;
   localparam int MAX_STEPS = 24;
   localparam logic signed [ACC_W-1:0] HALF_TURN = 26'sd11796480;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ANGLE_GAIN  = 3'd0;
   localparam logic [2:0] CSR_TEMP_GAIN   = 3'd1;
   localparam logic [2:0] CSR_TEMP_BIAS   = 3'd2;
   localparam logic [2:0] CSR_REF_ANGLE_X = 3'd3;
   localparam logic [2:0] CSR_REF_ANGLE_Y = 3'd4;
   localparam logic [2:0] CSR_REF_ANGLE_Z = 3'd5;
   localparam logic [2:0] CSR_TILT_LIMIT  = 3'd6;

   typedef struct packed {
      logic signed [11:0] accel_x;
      logic signed [11:0] accel_y;
      logic signed [11:0] accel_z;
      logic signed [11:0] temp_raw;
   } tam_req_type;

   typedef struct packed {
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic signed [15:0] temp_fahrenheit;
      logic signed [15:0] tilt_x;
      logic signed [15:0] tilt_y;
      logic signed [15:0] tilt_z;
      logic               moved;
   } tam_rsp_type;

   // Arctangent of 2^-i in degrees with 16 fraction bits, rounded to nearest.
   function automatic logic signed [ACC_W-1:0] atan_deg(input int i);
      logic signed [ACC_W-1:0] r;
      case (i)
         0:  r = 26'sd2949120;
         1:  r = 26'sd1740967;
         2:  r = 26'sd919879;
         3:  r = 26'sd466945;
         4:  r = 26'sd234379;
         5:  r = 26'sd117304;
         6:  r = 26'sd58666;
         7:  r = 26'sd29335;
         8:  r = 26'sd14668;
         9:  r = 26'sd7334;
         10: r = 26'sd3667;
         11: r = 26'sd1833;
         12: r = 26'sd917;
         13: r = 26'sd458;
         14: r = 26'sd229;
         15: r = 26'sd115;
         16: r = 26'sd57;
         17: r = 26'sd29;
         18: r = 26'sd14;
         19: r = 26'sd7;
         20: r = 26'sd4;
         21: r = 26'sd2;
         22: r = 26'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Saturate a wide signed value to 16 bits.
   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      logic signed [15:0] r;
      if (v > 40'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -40'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

### hdl/tam_isqrt.sv
// Pipelined floor square root, one root bit per stage, with a side value delayed alongside.
module tam_isqrt #(
   parameter int ROOT_W = 20,
   parameter int SIDE_W = 12
) (
   input  logic                     clock,
   input  logic                     advance,
   input  logic [2*ROOT_W-1:0]      radicand,
   input  logic signed [SIDE_W-1:0] side_in,
   output logic [ROOT_W-1:0]        root,
   output logic signed [SIDE_W-1:0] side_out
);
   import tam_pkg::*;

   logic [ROOT_W+1:0]          rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]          root_ff [ROOT_W];
   logic [2*ROOT_W-1:0]        bits_ff [ROOT_W];
   logic signed [SIDE_W-1:0]   side_ff [ROOT_W];
   logic [ROOT_W+1:0]          rem_in  [ROOT_W];
   logic [ROOT_W-1:0]          root_in [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [ROOT_W+1:0]   prev_rem;
      logic [ROOT_W-1:0]   prev_root;
      logic [2*ROOT_W-1:0] prev_bits;
      logic signed [SIDE_W-1:0] prev_side;
      logic [ROOT_W+1:0]   shifted;
      logic [ROOT_W+1:0]   trial;

      if (k == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_bits = radicand;
         assign prev_side = side_in;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
         assign prev_bits = bits_ff[k-1];
         assign prev_side = side_ff[k-1];
      end

      // Bring down the next two radicand bits and try the next root bit.
      always_comb begin
         shifted = {prev_rem[ROOT_W-1:0], prev_bits[2*ROOT_W-1:2*ROOT_W-2]};
         trial   = {prev_root, 2'b01};
         if (shifted >= trial) begin
            rem_in[k]  = shifted - trial;
            root_in[k] = {prev_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = shifted;
            root_in[k] = {prev_root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            bits_ff[k] <= {prev_bits[2*ROOT_W-3:0], 2'b00};
            side_ff[k] <= prev_side;
         end
      end
   end

   assign root     = root_ff[ROOT_W-1];
   assign side_out = side_ff[ROOT_W-1];

endmodule

### hdl/tam_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees with 16 fraction bits.
module tam_cordic #(
   parameter int W     = 22,
   parameter int STEPS = 16
) (
   input  logic                               clock,
   input  logic                               advance,
   input  logic signed [W-1:0]                y_in,
   input  logic signed [W-1:0]                x_in,
   output logic signed [tam_pkg::ACC_W-1:0]   angle
);
   import tam_pkg::*;

   logic signed [W-1:0]     x_ff   [STEPS+1];
   logic signed [W-1:0]     y_ff   [STEPS+1];
   logic signed [ACC_W-1:0] acc_ff [STEPS+1];
   logic                    zero_ff [STEPS+1];
   logic signed [W-1:0]     x_in_r [STEPS+1];
   logic signed [W-1:0]     y_in_r [STEPS+1];
   logic signed [ACC_W-1:0] acc_in [STEPS+1];

   // Fold the left half plane onto the right one with a half-turn offset.
   always_comb begin
      if (x_in[W-1]) begin
         x_in_r[0] = -x_in;
         y_in_r[0] = -y_in;
         acc_in[0] = y_in[W-1] ? -HALF_TURN : HALF_TURN;
      end else begin
         x_in_r[0] = x_in;
         y_in_r[0] = y_in;
         acc_in[0] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= x_in_r[0];
         y_ff[0]    <= y_in_r[0];
         acc_ff[0]  <= acc_in[0];
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
      end
   end

   // One micro-rotation per stage, driving y toward zero.
   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      logic signed [W-1:0] dx;
      logic signed [W-1:0] dy;

      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         if (!y_ff[i][W-1]) begin
            x_in_r[i+1] = x_ff[i] + dx;
            y_in_r[i+1] = y_ff[i] - dy;
            acc_in[i+1] = acc_ff[i] + atan_deg(i);
         end else begin
            x_in_r[i+1] = x_ff[i] - dx;
            y_in_r[i+1] = y_ff[i] + dy;
            acc_in[i+1] = acc_ff[i] - atan_deg(i);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1]    <= x_in_r[i+1];
            y_ff[i+1]    <= y_in_r[i+1];
            acc_ff[i+1]  <= acc_in[i+1];
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // A zero vector has angle zero.
   assign angle = zero_ff[STEPS] ? '0 : acc_ff[STEPS];

endmodule

### hdl/tam_scale.sv
// Per-axis angle gain, saturation and tilt against the reference, three stages.
module tam_scale (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [tam_pkg::ACC_W-1:0]  acc,
   input  logic [15:0]                       gain,
   input  logic signed [15:0]                ref_angle,
   output logic signed [15:0]                angle,
   output logic signed [15:0]                tilt
);
   import tam_pkg::*;

   localparam int PROD_W = ACC_W + 17;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] rounded;
   logic signed [15:0]       ang_ff, ang_in;
   logic signed [15:0]       ang_out_ff;
   logic signed [15:0]       tilt_ff, tilt_in;

   // Gain product, then round away the 23 fraction bits and saturate.
   always_comb begin
      prod_in = PROD_W'(acc) * PROD_W'($signed({1'b0, gain}));
      rounded = (prod_ff + PROD_W'(64'sd4194304)) >>> 23;
      ang_in  = sat16(40'(rounded));
      tilt_in = sat16(40'(ref_angle) - 40'(ang_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff    <= prod_in;
         ang_ff     <= ang_in;
         ang_out_ff <= ang_ff;
         tilt_ff    <= tilt_in;
      end
   end

   assign angle = ang_out_ff;
   assign tilt  = tilt_ff;

endmodule

### hdl/tam_temp.sv
// Temperature scaling to Celsius and conversion to Fahrenheit Q9.7, four stages.
module tam_temp #(
   parameter int SAMPLE_W = 12
) (
   input  logic                       clock,
   input  logic                       advance,
   input  logic signed [SAMPLE_W-1:0] temp_raw,
   input  logic [15:0]                gain,
   input  logic signed [15:0]         bias,
   output logic signed [15:0]         fahrenheit
);
   import tam_pkg::*;

   // 2560 = 512 * 5: shift by 9, then divide by 5 through a reciprocal.
   localparam logic signed [39:0] F_OFFSET = 40'sd10487040;
   localparam logic signed [39:0] DIV_BIAS = 40'sd2684354560;
   localparam logic signed [39:0] Q_BIAS   = 40'sd536870912;
   localparam logic [64:0]        RECIP5   = 65'd6871947674;

   logic signed [39:0] c16_ff, c16_in;
   logic signed [39:0] n_val;
   logic signed [39:0] m_val;
   logic [31:0]        u_ff, u_in;
   logic [64:0]        prod;
   logic [29:0]        q_ff, q_in;
   logic signed [15:0] f_ff, f_in;

   always_comb begin
      c16_in = 40'(temp_raw) * 40'($signed({1'b0, gain})) + 40'(bias) * 40'sd256;
      n_val  = c16_ff * 40'sd9 + F_OFFSET;
      m_val  = n_val >>> 9;
      // Offset keeps the dividend positive for the reciprocal step.
      u_in   = 32'(m_val + DIV_BIAS);
      prod   = 65'(u_ff) * RECIP5;
      q_in   = prod[64:35];
      f_in   = sat16(40'($signed({1'b0, q_ff})) - Q_BIAS);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c16_ff <= c16_in;
         u_ff   <= u_in;
         q_ff   <= q_in;
         f_ff   <= f_in;
      end
   end

   assign fahrenheit = f_ff;

endmodule

### hdl/accel_tilt_angle_monitor.sv
// Accelerometer tilt-angle monitor: top level with registers, lanes and merge stage.
// The monitor accepts one sample per clock while the pipeline is not held and returns
// one result per sample. Its datapath holds the square-root pipeline (one root bit per
// stage, SAMPLE_BITS + 8 stages) and the CORDIC pipeline (one micro-rotation per stage);
// each axis has its own square-root and CORDIC lane. When the result is not taken, the
// whole pipeline holds and req_ready drops. The user must write registers on the csr
// port only while no request is in flight; the block itself does not enforce this.
// Indexes beyond the last register are ignored.
module accel_tilt_angle_monitor #(
   parameter int CORDIC_STEPS = 16,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tam_pkg::tam_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tam_pkg::tam_rsp_type  rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_wdata
);
   import tam_pkg::*;

   localparam int S      = SAMPLE_BITS;
   localparam int ROOT_W = S + 8;
   localparam int CW     = S + 10;
   localparam int STEPS  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
   localparam int TR_D   = ROOT_W + STEPS + 1;
   localparam int VAL_D  = ROOT_W + STEPS + 6;

   // Configuration registers.
   logic [15:0]        angle_gain_ff;
   logic [15:0]        temp_gain_ff;
   logic signed [15:0] temp_bias_ff;
   logic signed [15:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic [14:0]        tilt_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_gain_ff <= 16'd16384;
         temp_gain_ff  <= 16'd4260;
         temp_bias_ff  <= '0;
         ref_x_ff      <= '0;
         ref_y_ff      <= '0;
         ref_z_ff      <= '0;
         tilt_limit_ff <= 15'd1280;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ANGLE_GAIN:  angle_gain_ff <= csr_wdata;
            CSR_TEMP_GAIN:   temp_gain_ff  <= csr_wdata;
            CSR_TEMP_BIAS:   temp_bias_ff  <= csr_wdata;
            CSR_REF_ANGLE_X: ref_x_ff      <= csr_wdata;
            CSR_REF_ANGLE_Y: ref_y_ff      <= csr_wdata;
            CSR_REF_ANGLE_Z: ref_z_ff      <= csr_wdata;
            CSR_TILT_LIMIT:  tilt_limit_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output register is free or being emptied.
   logic advance;
   logic valid_ff [VAL_D];

   assign advance   = !valid_ff[VAL_D-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[VAL_D-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VAL_D; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < VAL_D; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Input stage: read each field as SAMPLE_BITS bits and form the sums of squares.
   logic [S+11:0]          ext_x, ext_y, ext_z, ext_t;
   logic signed [S-1:0]    ax, ay, az, traw;
   logic [2*S-1:0]         sq_x, sq_y, sq_z;
   logic signed [S-1:0]    ax_ff, ay_ff, az_ff;
   logic [2*S-1:0]         sum_yz_ff, sum_xz_ff, sum_xy_ff;
   logic signed [S-1:0]    traw_ff [TR_D];

   always_comb begin
      ext_x = {{S{1'b0}}, req_data.accel_x};
      ext_y = {{S{1'b0}}, req_data.accel_y};
      ext_z = {{S{1'b0}}, req_data.accel_z};
      ext_t = {{S{1'b0}}, req_data.temp_raw};
      ax    = ext_x[S-1:0];
      ay    = ext_y[S-1:0];
      az    = ext_z[S-1:0];
      traw  = ext_t[S-1:0];
      sq_x  = ax * ax;
      sq_y  = ay * ay;
      sq_z  = az * az;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ff      <= ax;
         ay_ff      <= ay;
         az_ff      <= az;
         sum_yz_ff  <= sq_y + sq_z;
         sum_xz_ff  <= sq_x + sq_z;
         sum_xy_ff  <= sq_x + sq_y;
         traw_ff[0] <= traw;
         for (int i = 1; i < TR_D; i++) begin
            traw_ff[i] <= traw_ff[i-1];
         end
      end
   end

   // Square-root lanes; the 16 zero bits account for the scale of 256 per component.
   logic [ROOT_W-1:0]   mag_yz, mag_xz, mag_xy;
   logic signed [S-1:0] sx, sy, sz;

   tam_isqrt #(.ROOT_W(ROOT_W), .SIDE_W(S)) u_sqrt_x (
      .clock(clock), .advance(advance), .radicand({sum_yz_ff, 16'b0}),
      .side_in(ax_ff), .root(mag_yz), .side_out(sx));
   tam_isqrt #(.ROOT_W(ROOT_W), .SIDE_W(S)) u_sqrt_y (
      .clock(clock), .advance(advance), .radicand({sum_xz_ff, 16'b0}),
      .side_in(ay_ff), .root(mag_xz), .side_out(sy));
   tam_isqrt #(.ROOT_W(ROOT_W), .SIDE_W(S)) u_sqrt_z (
      .clock(clock), .advance(advance), .radicand({sum_xy_ff, 16'b0}),
      .side_in(az_ff), .root(mag_xy), .side_out(sz));

   // CORDIC lanes: x and y angles from the horizontal, z angle from the vertical.
   logic signed [CW-1:0]    cx_y, cy_y, cz_x;
   logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;

   assign cx_y = CW'(sx) <<< 8;
   assign cy_y = CW'(sy) <<< 8;
   assign cz_x = CW'(sz) <<< 8;

   tam_cordic #(.W(CW), .STEPS(STEPS)) u_cordic_x (
      .clock(clock), .advance(advance), .y_in(cx_y),
      .x_in($signed({2'b00, mag_yz})), .angle(acc_x));
   tam_cordic #(.W(CW), .STEPS(STEPS)) u_cordic_y (
      .clock(clock), .advance(advance), .y_in(cy_y),
      .x_in($signed({2'b00, mag_xz})), .angle(acc_y));
   tam_cordic #(.W(CW), .STEPS(STEPS)) u_cordic_z (
      .clock(clock), .advance(advance), .y_in($signed({2'b00, mag_xy})),
      .x_in(cz_x), .angle(acc_z));

   // Gain and tilt per lane.
   logic signed [15:0] ang_x, ang_y, ang_z, tlt_x, tlt_y, tlt_z, fahr;

   tam_scale u_scale_x (.clock(clock), .advance(advance), .acc(acc_x),
      .gain(angle_gain_ff), .ref_angle(ref_x_ff), .angle(ang_x), .tilt(tlt_x));
   tam_scale u_scale_y (.clock(clock), .advance(advance), .acc(acc_y),
      .gain(angle_gain_ff), .ref_angle(ref_y_ff), .angle(ang_y), .tilt(tlt_y));
   tam_scale u_scale_z (.clock(clock), .advance(advance), .acc(acc_z),
      .gain(angle_gain_ff), .ref_angle(ref_z_ff), .angle(ang_z), .tilt(tlt_z));

   // Temperature runs beside the last stages of the angle lanes.
   tam_temp #(.SAMPLE_W(S)) u_temp (.clock(clock), .advance(advance),
      .temp_raw(traw_ff[TR_D-1]), .gain(temp_gain_ff), .bias(temp_bias_ff),
      .fahrenheit(fahr));

   // Merge stage: compare the tilts with the limit and fill the output register.
   tam_rsp_type        rsp_ff, rsp_in;
   logic signed [16:0] lim;

   always_comb begin
      lim                    = $signed({2'b00, tilt_limit_ff});
      rsp_in.angle_x         = ang_x;
      rsp_in.angle_y         = ang_y;
      rsp_in.angle_z         = ang_z;
      rsp_in.temp_fahrenheit = fahr;
      rsp_in.tilt_x          = tlt_x;
      rsp_in.tilt_y          = tlt_y;
      rsp_in.tilt_z          = tlt_z;
      rsp_in.moved           = (17'(tlt_x) > lim) || (17'(tlt_y) > lim) || (17'(tlt_z) > lim);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### tb/accel_tilt_angle_monitor_tb.sv
// Self-checking testbench of the accelerometer tilt-angle monitor.
module accel_tilt_angle_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tam_pkg::*;

   localparam int LATENCY = 41;
   localparam int LIMIT_CYCLES = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tam_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   tam_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   accel_tilt_angle_monitor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register copies used by the predictor.
   logic [15:0] angle_gain_q;
   logic [15:0] temp_gain_q;
   logic [15:0] temp_bias_q;
   logic [15:0] ref_x_q;
   logic [15:0] ref_y_q;
   logic [15:0] ref_z_q;
   logic [14:0] tilt_limit_q;

   tam_req_type sample_queue[$];
   tam_rsp_type expected_results[$];
   int          errors = 0;
   int          results_seen = 0;
   int          moved_seen = 0;
   int          cycle_count = 0;
   bit          quiet_send = 0;
   bit          quiet_recv = 0;
   int          hold_off = 0;
   bit          hold_request = 0;

   // Integer square root, floor.
   function automatic longint root_floor(input longint n_in);
      longint n, r, b;
      n = n_in;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // Vectoring CORDIC: atan2(y, x) in degrees with 16 fraction bits.
   function automatic longint cordic_deg(input longint y_in, input longint x_in);
      longint acc, x, y, dx, dy;
      longint steps_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
         58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
         4, 2, 1, 0};
      acc = 0;
      x = x_in;
      y = y_in;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         acc = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; acc += steps_tab[i];
         end else begin
            x -= dx; y += dy; acc -= steps_tab[i];
         end
      end
      return acc;
   endfunction

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint gain_angle(input longint acc);
      longint p;
      p = acc * longint'(angle_gain_q) + (64'sd1 <<< 22);
      return clamp16(p >>> 23);
   endfunction

   // Expected result of one sample under the current register values.
   function automatic tam_rsp_type predict_tilt(input tam_req_type s);
      tam_rsp_type r;
      longint ax, ay, az, ang_x, ang_y, ang_z, c16, n, f, tx, ty, tz, lim;
      ax = longint'(s.accel_x) * 256;
      ay = longint'(s.accel_y) * 256;
      az = longint'(s.accel_z) * 256;
      ang_x = gain_angle(cordic_deg(ax, root_floor(ay * ay + az * az)));
      ang_y = gain_angle(cordic_deg(ay, root_floor(ax * ax + az * az)));
      ang_z = gain_angle(cordic_deg(root_floor(ax * ax + ay * ay), az));
      c16 = longint'(s.temp_raw) * longint'(temp_gain_q)
         + longint'($signed(temp_bias_q)) * 256;
      n = c16 * 9 + 5 * 32 * 65536 + 1280;
      if (n >= 0) f = n / 2560;
      else f = -((-n + 2559) / 2560);
      f = clamp16(f);
      tx = clamp16(longint'($signed(ref_x_q)) - ang_x);
      ty = clamp16(longint'($signed(ref_y_q)) - ang_y);
      tz = clamp16(longint'($signed(ref_z_q)) - ang_z);
      lim = longint'(tilt_limit_q);
      r.angle_x = ang_x[15:0];
      r.angle_y = ang_y[15:0];
      r.angle_z = ang_z[15:0];
      r.temp_fahrenheit = f[15:0];
      r.tilt_x = tx[15:0];
      r.tilt_y = ty[15:0];
      r.tilt_z = tz[15:0];
      r.moved = (tx > lim) || (ty > lim) || (tz > lim);
      return r;
   endfunction

   // Request driver: sends pending samples, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_tilt(req_data));
         end
         if (sample_queue.size() > 0 && (quiet_send || $urandom_range(99) >= 38)) begin
            req_valid <= 1'b1;
            req_data <= sample_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request && hold_off == 0) begin
         hold_off <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= (hold_off == 1);
      end else begin
         rsp_ready <= quiet_recv || ($urandom_range(99) >= 38);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      tam_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_data.moved) moved_seen++;
         if (expected_results.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            errors++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_data.angle_x !== e.angle_x) begin
               $error("angle_x exp %0d got %0d", e.angle_x, rsp_data.angle_x); errors++;
            end
            if (rsp_data.angle_y !== e.angle_y) begin
               $error("angle_y exp %0d got %0d", e.angle_y, rsp_data.angle_y); errors++;
            end
            if (rsp_data.angle_z !== e.angle_z) begin
               $error("angle_z exp %0d got %0d", e.angle_z, rsp_data.angle_z); errors++;
            end
            if (rsp_data.temp_fahrenheit !== e.temp_fahrenheit) begin
               $error("temp_fahrenheit exp %0d got %0d", e.temp_fahrenheit,
                  rsp_data.temp_fahrenheit); errors++;
            end
            if (rsp_data.tilt_x !== e.tilt_x) begin
               $error("tilt_x exp %0d got %0d", e.tilt_x, rsp_data.tilt_x); errors++;
            end
            if (rsp_data.tilt_y !== e.tilt_y) begin
               $error("tilt_y exp %0d got %0d", e.tilt_y, rsp_data.tilt_y); errors++;
            end
            if (rsp_data.tilt_z !== e.tilt_z) begin
               $error("tilt_z exp %0d got %0d", e.tilt_z, rsp_data.tilt_z); errors++;
            end
            if (rsp_data.moved !== e.moved) begin
               $error("moved exp %0b got %0b", e.moved, rsp_data.moved); errors++;
            end
         end
      end
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // One register write through the csr port with csr_valid then dropped; the predictor
   // copy follows it.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ANGLE_GAIN:  angle_gain_q = v;
         CSR_TEMP_GAIN:   temp_gain_q = v;
         CSR_TEMP_BIAS:   temp_bias_q = v;
         CSR_REF_ANGLE_X: ref_x_q = v;
         CSR_REF_ANGLE_Y: ref_y_q = v;
         CSR_REF_ANGLE_Z: ref_z_q = v;
         CSR_TILT_LIMIT:  tilt_limit_q = v[14:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [15:0] ag, input logic [15:0] tg,
                            input logic [15:0] tb, input logic [15:0] rx,
                            input logic [15:0] ry, input logic [15:0] rz,
                            input logic [15:0] tl);
      write_reg(CSR_ANGLE_GAIN, ag);
      write_reg(CSR_TEMP_GAIN, tg);
      write_reg(CSR_TEMP_BIAS, tb);
      write_reg(CSR_REF_ANGLE_X, rx);
      write_reg(CSR_REF_ANGLE_Y, ry);
      write_reg(CSR_REF_ANGLE_Z, rz);
      write_reg(CSR_TILT_LIMIT, tl);
   endtask

   // Waits until the pipeline has drained.
   task automatic drain();
      while (sample_queue.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic tam_req_type make_sample(input int x, input int y, input int z,
                                               input int t);
      tam_req_type s;
      s.accel_x = x[11:0];
      s.accel_y = y[11:0];
      s.accel_z = z[11:0];
      s.temp_raw = t[11:0];
      return s;
   endfunction

   // Random samples: half gravity-like vectors, a quarter full range and a quarter small.
   task automatic queue_random(input int count);
      int x, y, z;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: begin
               x = $urandom_range(4095) - 2048;
               y = $urandom_range(4095) - 2048;
               z = $urandom_range(4095) - 2048;
            end
            1: begin
               x = $urandom_range(7) - 4;
               y = $urandom_range(7) - 4;
               z = $urandom_range(7) - 4;
            end
            default: begin
               x = $urandom_range(400) - 200;
               y = $urandom_range(400) - 200;
               z = 1000 + $urandom_range(47);
               if ($urandom_range(1)) z = -z;
            end
         endcase
         sample_queue.push_back(make_sample(x, y, z, $urandom_range(4095) - 2048));
      end
   endtask

   // Test sequence.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      angle_gain_q = 16384;
      temp_gain_q = 4260;
      temp_bias_q = 0;
      ref_x_q = 0;
      ref_y_q = 0;
      ref_z_q = 0;
      tilt_limit_q = 1280;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples at reset settings: zero vector, axes, extremes.
      sample_queue.push_back(make_sample(0, 0, 0, 0));
      sample_queue.push_back(make_sample(2047, 0, 0, 2047));
      sample_queue.push_back(make_sample(-2048, 0, 0, -2048));
      sample_queue.push_back(make_sample(0, 2047, 0, 1));
      sample_queue.push_back(make_sample(0, -2048, 0, -1));
      sample_queue.push_back(make_sample(0, 0, 2047, 100));
      sample_queue.push_back(make_sample(0, 0, -2048, -100));
      sample_queue.push_back(make_sample(-2048, -2048, -2048, 0));
      sample_queue.push_back(make_sample(2047, 2047, 2047, 0));
      sample_queue.push_back(make_sample(-1, 1, -1, 0));
      sample_queue.push_back(make_sample(0, -1, 0, 0));
      drain();

      // Extreme registers force many outputs to saturate; unknown index is ignored.
      write_all(16'hffff, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      write_reg(3'd7, 16'h1234);
      sample_queue.push_back(make_sample(2047, 0, 0, 2047));
      sample_queue.push_back(make_sample(-2048, 0, 0, -2048));
      sample_queue.push_back(make_sample(0, 0, -2048, 2047));
      sample_queue.push_back(make_sample(1000, -1000, -1000, -2048));
      drain();
      write_all(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      sample_queue.push_back(make_sample(2047, 2047, 2047, 2047));
      sample_queue.push_back(make_sample(-5, 3, 900, -2048));
      drain();

      // Random phases with several register settings; one hold-off fills the pipe.
      write_all(16'd16384, 16'd4260, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1280);
      quiet_send = 1;
      quiet_recv = 1;
      queue_random(80);
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      drain();
      quiet_send = 0;
      quiet_recv = 0;
      for (int p = 0; p < 4; p++) begin
         write_all(16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(46080) - 23040), 16'($urandom_range(46080) - 23040),
                   16'($urandom_range(46080) - 23040), 16'($urandom_range(23040)));
         queue_random(115);
         drain();
      end

      $display("Checked %0d results (%0d with moved set) over 7 register settings.",
               results_seen, moved_seen);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
